// ===== hdl/cmoa_pkg.sv =====
// Shared types, constants and the arctangent table for the circular mean block.
package cmoa_pkg;

  // Datapath widths.
  localparam int XW           = 54;  // CORDIC x and y, large enough for sums scaled by 2^24
  localparam int ZW           = 27;  // CORDIC angle accumulator, degrees in Q16
  localparam int ANG_W        = 17;  // input angle after sign extension, 1/64 degree
  localparam int SC_W         = 16;  // one sine or cosine value, Q15
  localparam int SUM_W        = 27;  // running sums
  localparam int MEAN_W       = 15;  // result angle, 1/64 degree
  localparam int ATAN_ENTRIES = 24;
  localparam int IDX_W        = 5;   // index into the arctangent table

  typedef logic signed [XW-1:0]     vec_t;
  typedef logic signed [ZW-1:0]     ang_q16_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [SC_W-1:0]   q15_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [MEAN_W-1:0] mean_t;

  // Command from the sequencer to the shared CORDIC unit.
  typedef struct packed {
    logic start;
    logic vectoring;
  } cor_cmd_t;

  // Status from the shared CORDIC unit.
  typedef struct packed {
    logic busy;
    logic done;
  } cor_stat_t;

  // Angle constants in 1/64 degree.
  localparam ang_t FULL_TURN    = ANG_W'(23040);
  localparam ang_t HALF_TURN    = ANG_W'(11520);
  localparam ang_t QUARTER_TURN = ANG_W'(5760);

  // CORDIC constants.
  localparam vec_t     CORDIC_GAIN_Q30 = XW'(652032874);
  localparam ang_q16_t DEG90_Q16       = ZW'(5898240);

  // atan(2^-i) in degrees, Q16, rounded.
  function automatic ang_q16_t atan_q16(input logic [IDX_W-1:0] idx);
    ang_q16_t r;
    case (idx)
      5'd0:    r = ZW'(2949120);
      5'd1:    r = ZW'(1740967);
      5'd2:    r = ZW'(919879);
      5'd3:    r = ZW'(466945);
      5'd4:    r = ZW'(234379);
      5'd5:    r = ZW'(117304);
      5'd6:    r = ZW'(58666);
      5'd7:    r = ZW'(29335);
      5'd8:    r = ZW'(14668);
      5'd9:    r = ZW'(7334);
      5'd10:   r = ZW'(3667);
      5'd11:   r = ZW'(1833);
      5'd12:   r = ZW'(917);
      5'd13:   r = ZW'(458);
      5'd14:   r = ZW'(229);
      5'd15:   r = ZW'(115);
      5'd16:   r = ZW'(57);
      5'd17:   r = ZW'(29);
      5'd18:   r = ZW'(14);
      5'd19:   r = ZW'(7);
      5'd20:   r = ZW'(4);
      5'd21:   r = ZW'(2);
      5'd22:   r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/circular_mean_of_angles_top.sv =====
// Each angle request passes through the shared CORDIC unit, which runs one micro-rotation per cycle,
// then a rounding step and an accumulate step. After a request flagged last, the mean follows the
// accumulate, the vectoring load, the CORDIC pass (skipped when both sums are zero), rounding and
// the output register. A new request is taken only once the previous one reaches its accumulate
// step; after the last of a set, none is taken until the mean has gone to the output register.
// Synchronous reset clears the sequencer, both running sums and the output valid flag.
module circular_mean_of_angles_top import cmoa_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               angle_valid,
  output logic               angle_ready,
  input  logic signed [15:0] angle,
  input  logic               last,
  output logic               mean_valid,
  input  logic               mean_ready,
  output logic signed [14:0] mean_angle
);

  localparam int NUM_STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROT   = 6'b000010,
    S_ACC   = 6'b000100,
    S_VLOAD = 6'b001000,
    S_VRUN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  sum_t   sine_sum;
  sum_t   cosine_sum;
  logic   flip;
  logic   last_item;
  q15_t   sine_val;
  q15_t   cosine_val;
  mean_t  result;

  logic      accept;
  ang_t      ang_ext;
  ang_t      ang_wrap;
  ang_t      ang_fold;
  logic      fold_flip;
  cor_cmd_t  cor_cmd;
  cor_stat_t cor_stat;
  vec_t      cor_x_init;
  vec_t      cor_y_init;
  ang_q16_t  cor_z_init;
  vec_t      cor_x;
  vec_t      cor_y;
  ang_q16_t  cor_z;
  q15_t      sine_rnd;
  q15_t      cosine_rnd;
  sum_t      sine_sum_next;
  sum_t      cosine_sum_next;
  logic signed [SUM_W:0] vx;
  logic signed [SUM_W:0] vy;
  logic signed [SUM_W:0] vx_turn;
  logic signed [SUM_W:0] vy_turn;
  ang_q16_t  vz_init;
  logic      sums_zero;
  mean_t     mean_rnd;

  // Round a Q30 CORDIC output to Q15 and clamp to the symmetric range.
  function automatic q15_t round_q15(input vec_t v);
    vec_t r;
    q15_t q;
    r = (v + XW'(16384)) >>> 15;
    if (r > XW'(32767)) begin
      q = SC_W'(32767);
    end else if (r < -XW'(32767)) begin
      q = -SC_W'(32767);
    end else begin
      q = SC_W'(r);
    end
    return q;
  endfunction

  // Add one sample to a running sum, saturating at the sum limits.
  function automatic sum_t sat_add(input sum_t s, input q15_t v);
    logic signed [SUM_W:0] t;
    sum_t r;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(v);
    if (t[SUM_W] != t[SUM_W-1]) begin
      r = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = t[SUM_W-1:0];
    end
    return r;
  endfunction

  assign angle_ready = (state == S_IDLE) || (state == S_ACC && !last_item);
  assign accept      = angle_valid && angle_ready;

  // Fold the input angle into (-180, 180] and then into [-90, 90].
  always_comb begin
    ang_ext = ANG_W'(angle);
    if (ang_ext > HALF_TURN) begin
      ang_wrap = ang_ext - FULL_TURN;
    end else if (ang_ext <= -HALF_TURN) begin
      ang_wrap = ang_ext + FULL_TURN;
    end else begin
      ang_wrap = ang_ext;
    end
    fold_flip = 1'b0;
    if (ang_wrap > QUARTER_TURN) begin
      ang_fold  = ang_wrap - HALF_TURN;
      fold_flip = 1'b1;
    end else if (ang_wrap < -QUARTER_TURN) begin
      ang_fold  = ang_wrap + HALF_TURN;
      fold_flip = 1'b1;
    end else begin
      ang_fold = ang_wrap;
    end
  end

  // Vectoring start: a vector in the left half plane is turned by 90 degrees first.
  always_comb begin
    vx        = (SUM_W+1)'(cosine_sum);
    vy        = (SUM_W+1)'(sine_sum);
    sums_zero = (sine_sum == '0) && (cosine_sum == '0);
    if (vx[SUM_W]) begin
      if (!vy[SUM_W]) begin
        vx_turn = vy;
        vy_turn = -vx;
        vz_init = DEG90_Q16;
      end else begin
        vx_turn = -vy;
        vy_turn = vx;
        vz_init = -DEG90_Q16;
      end
    end else begin
      vx_turn = vx;
      vy_turn = vy;
      vz_init = '0;
    end
  end

  // Command and start values for the shared CORDIC unit.
  always_comb begin
    cor_cmd.start     = accept || (state == S_VLOAD && !sums_zero);
    cor_cmd.vectoring = (state == S_VLOAD);
    if (state == S_VLOAD) begin
      cor_x_init = XW'(vx_turn) <<< 24;
      cor_y_init = XW'(vy_turn) <<< 24;
      cor_z_init = vz_init;
    end else begin
      cor_x_init = CORDIC_GAIN_Q30;
      cor_y_init = '0;
      cor_z_init = ZW'(ang_fold) <<< 10;
    end
  end

  cmoa_cordic #(
    .NUM_STEPS(NUM_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cor_cmd),
    .x_init (cor_x_init),
    .y_init (cor_y_init),
    .z_init (cor_z_init),
    .stat   (cor_stat),
    .x      (cor_x),
    .y      (cor_y),
    .z      (cor_z)
  );

  // Rounding of the CORDIC results and the saturating sums.
  always_comb begin
    sine_rnd        = round_q15(cor_y);
    cosine_rnd      = round_q15(cor_x);
    sine_sum_next   = sat_add(sine_sum, sine_val);
    cosine_sum_next = sat_add(cosine_sum, cosine_val);
    begin
      logic signed [ZW:0] zr;
      zr = (ZW+1)'(cor_z) + (ZW+1)'(512);
      zr = zr >>> 10;
      if (zr > (ZW+1)'(11520)) begin
        mean_rnd = MEAN_W'(11520);
      end else if (zr < -(ZW+1)'(11520)) begin
        mean_rnd = -MEAN_W'(11520);
      end else begin
        mean_rnd = MEAN_W'(zr);
      end
    end
  end

  // Sequencer, running sums and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sine_sum   <= '0;
      cosine_sum <= '0;
      mean_valid <= 1'b0;
    end else begin
      // The output valid rises when a mean is handed over and drops when it is taken.
      if (state == S_EMIT && (!mean_valid || mean_ready)) begin
        mean_valid <= 1'b1;
      end else if (mean_valid && mean_ready) begin
        mean_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (cor_stat.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sine_sum   <= sine_sum_next;
          cosine_sum <= cosine_sum_next;
          if (last_item) begin
            state <= S_VLOAD;
          end else if (accept) begin
            state <= S_ROT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_VLOAD: begin
          sine_sum   <= '0;
          cosine_sum <= '0;
          state      <= sums_zero ? S_EMIT : S_VRUN;
        end
        S_VRUN: begin
          if (cor_stat.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!mean_valid || mean_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      flip      <= fold_flip;
      last_item <= last;
    end
    if (state == S_ROT && cor_stat.done) begin
      sine_val   <= flip ? -sine_rnd : sine_rnd;
      cosine_val <= flip ? -cosine_rnd : cosine_rnd;
    end
    if (state == S_VLOAD) begin
      result <= '0;
    end else if (state == S_VRUN && cor_stat.done) begin
      result <= mean_rnd;
    end
    if (state == S_EMIT && (!mean_valid || mean_ready)) begin
      mean_angle <= result;
    end
  end

  // An accepted angle always starts a rotation pass.
  a_accept_rot: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_ROT && cor_stat.busy)
    else $error("accepted angle did not start a rotation");

  // The sums are cleared once a set has been handed to the vectoring pass.
  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_VLOAD |=> sine_sum == '0 && cosine_sum == '0)
    else $error("sums not cleared after last angle");

  // The shared unit is never busy while a new angle may be taken.
  a_ready_idle_unit: assert property (@(posedge clk) disable iff (rst)
    angle_ready |-> !cor_stat.busy)
    else $error("ready while cordic busy");

  // The mean stays within half a turn.
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    mean_valid |-> mean_angle >= -15'sd11520 && mean_angle <= 15'sd11520)
    else $error("mean angle out of range");

endmodule

// ===== hdl/cmoa_cordic.sv =====
// Shared iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module cmoa_cordic import cmoa_pkg::*; #(
  parameter int NUM_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cor_cmd_t  cmd,
  input  vec_t      x_init,
  input  vec_t      y_init,
  input  ang_q16_t  z_init,
  output cor_stat_t stat,
  output vec_t      x,
  output vec_t      y,
  output ang_q16_t  z
);

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_STEPS - 1);

  logic             running;
  logic             done;
  logic             vectoring;
  logic [IDX_W-1:0] step;

  vec_t     x_sh;
  vec_t     y_sh;
  ang_q16_t atan_step;
  logic     turn_pos;
  vec_t     x_next;
  vec_t     y_next;
  ang_q16_t z_next;

  // One micro-rotation: the direction follows z in rotation mode and y in vectoring mode.
  always_comb begin
    x_sh      = x >>> step;
    y_sh      = y >>> step;
    atan_step = atan_q16(step);
    turn_pos  = vectoring ? y[XW-1] : ~z[ZW-1];
    if (turn_pos) begin
      x_next = x - y_sh;
      y_next = y + x_sh;
      z_next = z - atan_step;
    end else begin
      x_next = x + y_sh;
      y_next = y - x_sh;
      z_next = z + atan_step;
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x         <= x_init;
      y         <= y_init;
      z         <= z_init;
      vectoring <= cmd.vectoring;
    end else if (running) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign stat.busy = running;
  assign stat.done = done;

  // A new pass never starts on top of one in progress.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !running)
    else $error("cordic started while busy");

  // Completion is flagged in the cycle after the last micro-rotation.
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    running && !cmd.start && step == LAST_STEP |=> done && !running)
    else $error("cordic did not complete after its last step");

  // Completion is only flagged once the unit has stopped.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !running && $past(running))
    else $error("cordic done without a finished pass");

endmodule
